>>> rtl/sct_pkg.sv
// Shared types and constants of the segment collision table.
`default_nettype none

package sct_pkg;

    localparam int ENTRIES_PER_TABLE = 64;
    localparam int COORD_W           = 16;
    localparam int DIST_W            = 8;
    // Position compare width: a coordinate plus or minus the distance must not wrap.
    localparam int NEAR_W            = COORD_W + 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos;
        logic signed [COORD_W-1:0] lo;
        logic signed [COORD_W-1:0] hi;
    } seg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

>>> rtl/segment_collision_table_top.sv
// Top level of the segment collision table: item handshake, sequencing and result register.
// Each item is first captured with its span ends ordered, then every cell of the selected table
// compares its stored segment against it in parallel (or the table shifts the new segment in),
// and then the cells' match bits are ORed into the result register once the output side can
// take it. A new item is accepted once the previous result has been loaded into the output
// register. Each table is a row of ENTRIES_PER_TABLE cells; an insert into a full table is
// dropped and flagged.
`default_nettype none

module segment_collision_table_top #(
    parameter int ENTRIES_PER_TABLE = sct_pkg::ENTRIES_PER_TABLE
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [sct_pkg::DIST_W-1:0]         cfg_data,
    input  wire logic                               in_valid,
    output      logic                               in_stall,
    input  wire logic                               operation,
    input  wire logic                               is_vertical,
    input  wire logic signed [sct_pkg::COORD_W-1:0] line_position,
    input  wire logic signed [sct_pkg::COORD_W-1:0] span_first,
    input  wire logic signed [sct_pkg::COORD_W-1:0] span_last,
    output      logic                               out_valid,
    input  wire logic                               out_stall,
    output      logic                               hit,
    output      logic                               table_full
);

    sct_pkg::state_t state_reg;
    sct_pkg::state_t state_next;

    logic [sct_pkg::DIST_W-1:0] min_distance_reg;
    logic                       op_reg;
    logic                       vert_reg;
    sct_pkg::seg_t              qseg_reg;
    sct_pkg::seg_t              qseg_next;
    logic                       full_reg;
    logic                       full_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       hit_reg;
    logic                       hit_next;
    logic                       table_full_reg;
    logic                       table_full_next;

    logic accept;
    logic load_out;
    logic v_insert;
    logic h_insert;
    logic v_full;
    logic h_full;
    logic v_hit;
    logic h_hit;

    assign in_stall = (state_reg != sct_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        qseg_next.pos = line_position;
        qseg_next.lo  = (span_first > span_last) ? span_last : span_first;
        qseg_next.hi  = (span_first > span_last) ? span_first : span_last;
    end

    always_comb
    begin
        state_next      = state_reg;
        v_insert        = 1'b0;
        h_insert        = 1'b0;
        full_next       = full_reg;
        load_out        = 1'b0;
        hit_next        = hit_reg;
        table_full_next = table_full_reg;
        unique case (state_reg)
            sct_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = sct_pkg::ST_EVAL;
                end
            end
            sct_pkg::ST_EVAL:
            begin
                if (op_reg == sct_pkg::OP_INSERT)
                begin
                    v_insert  = vert_reg;
                    h_insert  = !vert_reg;
                    full_next = vert_reg ? v_full : h_full;
                end
                else
                begin
                    full_next = 1'b0;
                end
                state_next = sct_pkg::ST_RESULT;
            end
            sct_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out        = 1'b1;
                    hit_next        = (op_reg == sct_pkg::OP_QUERY) && (vert_reg ? v_hit : h_hit);
                    table_full_next = full_reg;
                    state_next      = sct_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sct_pkg::ST_IDLE;
            end
        endcase
        out_valid_next = load_out || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sct_pkg::ST_IDLE;
            out_valid_reg    <= 1'b0;
            min_distance_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                min_distance_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= operation;
            vert_reg <= is_vertical;
            qseg_reg <= qseg_next;
        end
        full_reg       <= full_next;
        hit_reg        <= hit_next;
        table_full_reg <= table_full_next;
    end

    sct_chain #(
        .ENTRIES (ENTRIES_PER_TABLE)
    ) u_vert (
        .clk       (clk),
        .rst_n     (rst_n),
        .insert_en (v_insert),
        .seg_in    (qseg_reg),
        .min_dist  (min_distance_reg),
        .full      (v_full),
        .hit       (v_hit)
    );

    sct_chain #(
        .ENTRIES (ENTRIES_PER_TABLE)
    ) u_horz (
        .clk       (clk),
        .rst_n     (rst_n),
        .insert_en (h_insert),
        .seg_in    (qseg_reg),
        .min_dist  (min_distance_reg),
        .full      (h_full),
        .hit       (h_hit)
    );

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign table_full = table_full_reg;

endmodule

`default_nettype wire

>>> rtl/sct_cell.sv
// One storage cell: holds a segment, passes it on to the next cell, and checks it against a query.
`default_nettype none

module sct_cell (
    input  wire logic                           clk,
    input  wire logic                           shift_en,
    input  wire sct_pkg::seg_t                  seg_in,
    input  wire logic                           valid,
    input  wire sct_pkg::seg_t                  qry,
    input  wire logic [sct_pkg::DIST_W-1:0]     min_dist,
    output      sct_pkg::seg_t                  seg_out,
    output      logic                           match
);

    sct_pkg::seg_t seg_reg;
    logic          match_reg;
    logic          match_next;

    logic signed [sct_pkg::NEAR_W-1:0] s_pos;
    logic signed [sct_pkg::NEAR_W-1:0] q_pos;
    logic signed [sct_pkg::NEAR_W-1:0] d_ext;
    logic                              near;
    logic                              span_cross;

    always_comb
    begin
        s_pos = sct_pkg::NEAR_W'(seg_reg.pos);
        q_pos = sct_pkg::NEAR_W'(qry.pos);
        d_ext = $signed({{(sct_pkg::NEAR_W - sct_pkg::DIST_W){1'b0}}, min_dist});
        near  = (s_pos + d_ext >= q_pos) && (s_pos - d_ext <= q_pos);
        // Strict overlap: some end of one span lies strictly inside the other span.
        span_cross = (qry.lo > seg_reg.lo && qry.lo < seg_reg.hi) ||
                     (qry.hi > seg_reg.lo && qry.hi < seg_reg.hi) ||
                     (seg_reg.lo > qry.lo && seg_reg.lo < qry.hi) ||
                     (seg_reg.hi > qry.lo && seg_reg.hi < qry.hi);
        match_next = valid && near && span_cross;
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            seg_reg <= seg_in;
        end
        match_reg <= match_next;
    end

    assign seg_out = seg_reg;
    assign match   = match_reg;

endmodule

`default_nettype wire

>>> rtl/sct_chain.sv
// One table: a row of cells that shifts in new segments, with its fill count and hit reduction.
`default_nettype none

module sct_chain #(
    parameter int ENTRIES = sct_pkg::ENTRIES_PER_TABLE
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           insert_en,
    input  wire sct_pkg::seg_t                  seg_in,
    input  wire logic [sct_pkg::DIST_W-1:0]     min_dist,
    output      logic                           full,
    output      logic                           hit
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             shift_en;
    logic [ENTRIES-1:0] match_bits;
    sct_pkg::seg_t    cell_seg [ENTRIES];

    assign full     = (count_reg == CNT_W'(ENTRIES));
    assign shift_en = insert_en && !full;

    always_comb
    begin
        count_next = count_reg;
        if (shift_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // New segments enter at cell 0, so cells below the count hold the stored segments.
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        sct_cell u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .seg_in   ((i == 0) ? seg_in : cell_seg[(i == 0) ? 0 : i - 1]),
            .valid    (CNT_W'(i) < count_reg),
            .qry      (seg_in),
            .min_dist (min_dist),
            .seg_out  (cell_seg[i]),
            .match    (match_bits[i])
        );
    end

    assign hit = |match_bits;

endmodule

`default_nettype wire
